@@ rtl/okvt_pkg.sv @@
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types, codes and helpers for the ordered key/value table unit.
// ----------------------------------------------------------------------------
package okvt_pkg;

	// fixed field widths of the channels
	localparam int OP_W     = 3;
	localparam int WORD_W   = 64;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 9;

	// default geometry
	localparam int ENTRIES_DEF     = 256;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BYTES_DEF = 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_SET     = 3'd0;
	localparam logic [OP_W-1:0] OP_GET     = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_GETSIZE = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_RESP
	} okvt_state_t;

	// all-ones over the low len bytes of a word
	function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W / 8; b++) begin
			m[8*b +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

@@ rtl/okvt_if.sv @@
// ----------------------------------------------------------------------------
// okvt_req_if / okvt_rsp_if
// Valid/ready channels carrying request and response items of the table.
// ----------------------------------------------------------------------------
interface okvt_req_if;
	import okvt_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [WORD_W-1:0] key_word;
	logic [LEN_W-1:0]  key_length;
	logic [WORD_W-1:0] value_word;
	logic [LEN_W-1:0]  value_length;

	modport source (output valid, operation, key_word, key_length, value_word,
		value_length, input ready);
	modport sink (input valid, operation, key_word, key_length, value_word,
		value_length, output ready);
endinterface

interface okvt_rsp_if;
	import okvt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   found_value;
	logic [LEN_W-1:0]    found_length;
	logic [SIZE_W-1:0]   size_now;

	modport source (output valid, status, found_value, found_length, size_now,
		input ready);
	modport sink (input valid, status, found_value, found_length, size_now,
		output ready);
endinterface

@@ rtl/okvt_ram.sv @@
// ----------------------------------------------------------------------------
// okvt_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module okvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/ordered_key_value_table_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_key_value_table_unit
// Fixed-capacity key/value table in first-write order with linear search,
// in-place replace, append, delete with compaction, clear and size query.
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake    | payload
// ----------+-----+--------------+-------------------------------------------------
// request   | in  | valid/ready  | operation, key_word, key_length, value_word,
//           |     |              | value_length
// response  | out | valid/ready  | status, found_value, found_length, size_now
//
// order: clear, getsize and items refused on intake go straight to S_RESP and
// then to the response register; a scan reads one entry per cycle and compares
// it in the next cycle, and a hit or a miss then passes through S_RESP; a delete
// hit first compacts in S_SHIFT, moving every later entry down by one
// reset: idle, count zero; ram entries at or above the count are never read
// stalls: a new item is taken while the last response waits; only S_RESP holds
// ----------------------------------------------------------------------------
module ordered_key_value_table_unit #(
	parameter int ENTRIES     = okvt_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES   = okvt_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = okvt_pkg::VALUE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	okvt_req_if.sink   request,
	okvt_rsp_if.source response
);
	import okvt_pkg::*;

	// geometry derived from the parameters
	localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW       = $clog2(ENTRIES + 1);
	localparam int KEY_BITS = 8 * KEY_BYTES;
	localparam int VAL_BITS = 8 * VALUE_BYTES;
	localparam int EW       = KEY_BITS + LEN_W + VAL_BITS + LEN_W;

	localparam logic [CW-1:0]    ENT_C = CW'(ENTRIES);
	localparam logic [LEN_W-1:0] KB_L  = LEN_W'(KEY_BYTES);
	localparam logic [LEN_W-1:0] VB_L  = LEN_W'(VALUE_BYTES);

	// control state
	okvt_state_t st_q, st_n;
	logic [CW-1:0] cnt_q, cnt_n;      // entries held
	logic [CW-1:0] rd_q, rd_n;        // next ram index to read
	logic          pend_s1, pend_n;   // a read is in flight, data valid now
	logic [AW-1:0] pidx_s1, pidx_n;   // index of the read in flight
	logic          out_valid_q;
	logic          load_out;

	// latched item
	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LEN_W-1:0]    klen_q;
	logic [VAL_BITS-1:0] val_q;
	logic [LEN_W-1:0]    vlen_q;

	// pending result
	logic [STATUS_W-1:0] res_st_q, res_st_n;
	logic [VAL_BITS-1:0] res_val_q, res_val_n;
	logic [LEN_W-1:0]    res_len_q, res_len_n;

	// response register
	logic [STATUS_W-1:0] out_status_q;
	logic [WORD_W-1:0]   out_value_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [SIZE_W-1:0]   out_size_q;

	// entry ram, layout {value_len, value, key_len, key}
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	logic [KEY_BITS-1:0] r_key;
	logic [LEN_W-1:0]    r_klen;
	logic [VAL_BITS-1:0] r_val;
	logic [LEN_W-1:0]    r_vlen;
	logic [EW-1:0]       new_entry;
	logic                hit;
	logic                accept;
	logic                set_bad;
	logic [WORD_W-1:0]   key_in_m, val_in_m;

	okvt_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign r_key  = mem_rdata[0 +: KEY_BITS];
	assign r_klen = mem_rdata[KEY_BITS +: LEN_W];
	assign r_val  = mem_rdata[KEY_BITS + LEN_W +: VAL_BITS];
	assign r_vlen = mem_rdata[KEY_BITS + LEN_W + VAL_BITS +: LEN_W];

	assign new_entry = {vlen_q, val_q, klen_q, key_q};

	// stored keys are masked and 1..KEY_BYTES long, so a bad length never hits
	assign hit = pend_s1 && (r_klen == klen_q) && (r_key == key_q);

	assign accept   = request.valid && request.ready;
	assign key_in_m = request.key_word & byte_mask(request.key_length);
	assign val_in_m = request.value_word & byte_mask(request.value_length);
	assign set_bad  = (request.key_length == '0) || (request.key_length > KB_L)
		|| (request.value_length > VB_L);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_n;
			cnt_q   <= cnt_n;
			pend_s1 <= pend_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		rd_q      <= rd_n;
		pidx_s1   <= pidx_n;
		res_st_q  <= res_st_n;
		res_val_q <= res_val_n;
		res_len_q <= res_len_n;
		if (accept) begin
			op_q   <= request.operation;
			key_q  <= key_in_m[KEY_BITS-1:0];
			klen_q <= request.key_length;
			val_q  <= val_in_m[VAL_BITS-1:0];
			vlen_q <= request.value_length;
		end
		if (load_out) begin
			out_status_q <= res_st_q;
			out_value_q  <= WORD_W'(res_val_q);
			out_len_q    <= res_len_q;
			out_size_q   <= SIZE_W'(cnt_q);
		end
	end

	always_comb begin
		st_n      = st_q;
		cnt_n     = cnt_q;
		rd_n      = rd_q;
		pend_n    = 1'b0;
		pidx_n    = pidx_s1;
		res_st_n  = res_st_q;
		res_val_n = res_val_q;
		res_len_n = res_len_q;
		mem_re    = 1'b0;
		mem_raddr = rd_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = pidx_s1;
		mem_wdata = new_entry;
		load_out  = 1'b0;
		request.ready = (st_q == S_IDLE);

		unique case (st_q)
			S_IDLE: begin
				if (request.valid) begin
					res_st_n  = ST_OK;
					res_val_n = '0;
					res_len_n = '0;
					rd_n      = '0;
					unique case (request.operation) inside
						OP_SET: begin
							if (set_bad) begin
								res_st_n = ST_REFUSED;
								st_n     = S_RESP;
							end else begin
								st_n = S_SEARCH;
							end
						end
						OP_GET, OP_DELETE: begin
							st_n = S_SEARCH;
						end
						OP_CLEAR: begin
							cnt_n = '0;
							st_n  = S_RESP;
						end
						OP_GETSIZE: begin
							st_n = S_RESP;
						end
						default: begin
							res_st_n = ST_REFUSED;
							st_n     = S_RESP;
						end
					endcase
				end
			end

			S_SEARCH: begin
				if (hit) begin
					unique case (op_q)
						OP_GET: begin
							res_val_n = r_val;
							res_len_n = r_vlen;
							st_n      = S_RESP;
						end
						OP_SET: begin
							// replace in place, key bytes are identical
							mem_we    = 1'b1;
							mem_waddr = pidx_s1;
							st_n      = S_RESP;
						end
						OP_DELETE: begin
							rd_n = CW'(pidx_s1) + CW'(1);
							st_n = S_SHIFT;
						end
						default: begin
							res_st_n = ST_REFUSED;
							st_n     = S_RESP;
						end
					endcase
				end else if (rd_q < cnt_q) begin
					mem_re = 1'b1;
					rd_n   = rd_q + CW'(1);
					pend_n = 1'b1;
					pidx_n = rd_q[AW-1:0];
				end else begin
					// every held entry compared, none matched
					st_n = S_RESP;
					unique case (op_q)
						OP_GET: begin
							res_st_n = ST_MISS;
						end
						OP_SET: begin
							if (cnt_q == ENT_C) begin
								res_st_n = ST_REFUSED;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[AW-1:0];
								cnt_n     = cnt_q + CW'(1);
							end
						end
						default: begin
							res_st_n = ST_REFUSED;
						end
					endcase
				end
			end

			S_SHIFT: begin
				// entry read last cycle moves down by one
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pidx_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (rd_q < cnt_q) begin
					mem_re = 1'b1;
					rd_n   = rd_q + CW'(1);
					pend_n = 1'b1;
					pidx_n = rd_q[AW-1:0];
				end else if (!pend_s1) begin
					cnt_n = cnt_q - CW'(1);
					st_n  = S_RESP;
				end
			end

			S_RESP: begin
				if (!out_valid_q || response.ready) begin
					load_out = 1'b1;
					st_n     = S_IDLE;
				end
			end

			default: begin
				st_n = S_IDLE;
			end
		endcase
	end

	assign response.valid        = out_valid_q;
	assign response.status       = out_status_q;
	assign response.found_value  = out_value_q;
	assign response.found_length = out_len_q;
	assign response.size_now     = out_size_q;

`ifndef NO_ASSERTIONS
	// the count never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ENT_C)
		else $error("entry count above capacity");

	// writes stay inside the held entries or append right after them
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= cnt_q))
		else $error("ram write beyond the table");

	// a read in flight only exists while scanning or compacting
	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (st_q == S_SEARCH || st_q == S_SHIFT))
		else $error("stray ram read in flight");

	// a clear empties the table
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.operation == OP_CLEAR) |=> (cnt_q == '0))
		else $error("clear left entries");

	// finishing a compaction removes exactly one entry
	a_delete: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SHIFT && st_n == S_RESP) |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("delete did not drop one entry");
`endif
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered key/value table unit: directed corner
// items, a fill to full capacity with deep deletes, then random rounds over
// small and large key pools, checked against a cycle-free table predictor.
// ----------------------------------------------------------------------------
module testbench;
	import okvt_pkg::*;

	typedef struct {
		logic [OP_W-1:0]   operation;
		logic [WORD_W-1:0] key_word;
		logic [LEN_W-1:0]  key_length;
		logic [WORD_W-1:0] value_word;
		logic [LEN_W-1:0]  value_length;
	} kv_request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   found_value;
		logic [LEN_W-1:0]    found_length;
		logic [SIZE_W-1:0]   size_now;
	} kv_answer_t;

	// low n bytes of a word kept, the rest cleared
	function automatic logic [WORD_W-1:0] keep_bytes(logic [WORD_W-1:0] w,
			logic [LEN_W-1:0] n);
		if (n >= WORD_W / 8)
			return w;
		return w & ((64'd1 << (8 * int'(n))) - 64'd1);
	endfunction

	class kv_table_tracker;
		logic [WORD_W-1:0] stored_key [ENTRIES_DEF];
		logic [LEN_W-1:0]  stored_key_len [ENTRIES_DEF];
		logic [WORD_W-1:0] stored_value [ENTRIES_DEF];
		logic [LEN_W-1:0]  stored_value_len [ENTRIES_DEF];
		int                held;
		kv_answer_t        awaited_answers[$];
		int                failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		// position of the entry with this key, or held on a miss
		function int locate(logic [WORD_W-1:0] key, logic [LEN_W-1:0] len);
			logic [WORD_W-1:0] k;
			k = keep_bytes(key, len);
			for (int i = 0; i < held; i++) begin
				if (stored_key_len[i] == len && stored_key[i] == k)
					return i;
			end
			return held;
		endfunction

		// applies one request to the table copy and returns the answer it gives
		function kv_answer_t table_answer(kv_request_t r);
			kv_answer_t a;
			int at;
			a.status = ST_OK;
			a.found_value = '0;
			a.found_length = '0;
			case (r.operation)
				OP_SET: begin
					if (r.key_length == 0 || r.key_length > KEY_BYTES_DEF ||
							r.value_length > VALUE_BYTES_DEF) begin
						a.status = ST_REFUSED;
					end else begin
						at = locate(r.key_word, r.key_length);
						if (at < held) begin
							stored_value[at] = keep_bytes(r.value_word, r.value_length);
							stored_value_len[at] = r.value_length;
						end else if (held >= ENTRIES_DEF) begin
							a.status = ST_REFUSED;
						end else begin
							stored_key[held] = keep_bytes(r.key_word, r.key_length);
							stored_key_len[held] = r.key_length;
							stored_value[held] = keep_bytes(r.value_word, r.value_length);
							stored_value_len[held] = r.value_length;
							held++;
						end
					end
				end
				OP_GET: begin
					at = locate(r.key_word, r.key_length);
					if (at < held) begin
						a.found_value = stored_value[at];
						a.found_length = stored_value_len[at];
					end else begin
						a.status = ST_MISS;
					end
				end
				OP_DELETE: begin
					at = locate(r.key_word, r.key_length);
					if (at < held) begin
						for (int j = at; j < held - 1; j++) begin
							stored_key[j] = stored_key[j+1];
							stored_key_len[j] = stored_key_len[j+1];
							stored_value[j] = stored_value[j+1];
							stored_value_len[j] = stored_value_len[j+1];
						end
						held--;
					end else begin
						a.status = ST_REFUSED;
					end
				end
				OP_CLEAR: begin
					held = 0;
				end
				OP_GETSIZE: begin
				end
				default: begin
					a.status = ST_REFUSED;
				end
			endcase
			a.size_now = SIZE_W'(held);
			return a;
		endfunction

		function void note_request(kv_request_t r);
			awaited_answers = {awaited_answers, table_answer(r)};
		endfunction

		function void check_response(kv_answer_t got);
			kv_answer_t want;
			if (awaited_answers.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response: status %0d value %h len %0d size %0d",
						got.status, got.found_value, got.found_length, got.size_now);
				return;
			end
			want = awaited_answers.pop_front();
			if (got.status !== want.status || got.found_value !== want.found_value ||
					got.found_length !== want.found_length ||
					got.size_now !== want.size_now) begin
				failures++;
				if (failures <= 10) begin
					$write("mismatch: expected status %0d value %h len %0d size %0d, ",
						want.status, want.found_value, want.found_length, want.size_now);
					$display("got status %0d value %h len %0d size %0d",
						got.status, got.found_value, got.found_length, got.size_now);
				end
			end
		endfunction

		function int awaited();
			return awaited_answers.size();
		endfunction
	endclass

	localparam logic [OP_W-1:0]  OP_TOP  = '1;
	localparam logic [LEN_W-1:0] LEN_TOP = '1;
	localparam int               TAIL_CYCLES = 2 * ENTRIES_DEF + 64;

	logic clk = 1'b0;
	logic arst_n;

	okvt_req_if request_ch();
	okvt_rsp_if response_ch();

	ordered_key_value_table_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.response(response_ch)
	);

	kv_table_tracker tracker = new();

	// when set, neither side inserts gaps or stalls
	bit steady = 1'b0;
	int items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic kv_request_t make_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] key,
			logic [LEN_W-1:0] klen, logic [WORD_W-1:0] val, logic [LEN_W-1:0] vlen);
		kv_request_t r;
		r.operation = op;
		r.key_word = key;
		r.key_length = klen;
		r.value_word = val;
		r.value_length = vlen;
		return r;
	endfunction

	// present one item after a random gap, return once it is taken
	task automatic send_item(input kv_request_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.operation <= item.operation;
		request_ch.key_word <= item.key_word;
		request_ch.key_length <= item.key_length;
		request_ch.value_word <= item.value_word;
		request_ch.value_length <= item.value_length;
		@(posedge clk);
		while (request_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_request(item);
		items_sent++;
	endtask

	// drop valid and hold off until every answer is back
	task automatic settle_table();
		@(negedge clk);
		request_ch.valid <= 1'b0;
		while (tracker.awaited() != 0) @(posedge clk);
	endtask

	// corner items: refusals, empty value, ignored key bytes, unknown codes
	task automatic run_directed();
		logic [WORD_W-1:0] k_c;
		k_c = 64'h0000_0000_00C3_B2A1;
		send_item(make_item(OP_GETSIZE, '0, '0, '0, '0));
		send_item(make_item(OP_GET, 64'h0000_0000_0033_2211, 4'd3, '0, '0));
		send_item(make_item(OP_DELETE, 64'h0000_0000_0033_2211, 4'd3, '0, '0));
		// bad key lengths and an over-long value on set
		send_item(make_item(OP_SET, rand_word(), 4'd0, rand_word(), 4'd4));
		send_item(make_item(OP_SET, rand_word(), 4'd9, rand_word(), 4'd4));
		send_item(make_item(OP_SET, '1, LEN_TOP, '1, LEN_TOP));
		send_item(make_item(OP_SET, rand_word(), 4'd4, rand_word(), 4'd9));
		// one-byte key with an empty value
		send_item(make_item(OP_SET, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '1, 4'd0));
		send_item(make_item(OP_GET, 64'h1234_5678_9ABC_DE00, 4'd1, '0, '0));
		// all-ones key and value at full width
		send_item(make_item(OP_SET, '1, 4'd8, '1, 4'd8));
		send_item(make_item(OP_GET, '1, 4'd8, '0, '0));
		// key bytes past the length must not matter
		send_item(make_item(OP_SET, k_c | 64'hDEAD_BEEF_5500_0000, 4'd3, rand_word(), 4'd5));
		send_item(make_item(OP_GET, k_c | 64'h0102_0304_0500_0000, 4'd3, '0, '0));
		send_item(make_item(OP_GET, k_c, 4'd4, '0, '0));
		// in-place replace, then read back
		send_item(make_item(OP_SET, k_c, 4'd3, rand_word(), 4'd8));
		send_item(make_item(OP_GET, k_c, 4'd3, '0, '0));
		// bad key on get and delete
		send_item(make_item(OP_GET, '0, 4'd0, '0, '0));
		send_item(make_item(OP_GET, '1, 4'd12, '0, '0));
		send_item(make_item(OP_DELETE, '1, 4'd9, '0, '0));
		// unknown operation codes
		for (int c = OP_GETSIZE + 1; c <= OP_TOP; c++)
			send_item(make_item(OP_W'(c), rand_word(), 4'($urandom_range(0, LEN_TOP)),
				rand_word(), 4'($urandom_range(0, LEN_TOP))));
		// delete the front entry so the rest move down
		send_item(make_item(OP_DELETE, 64'h0000_0000_0000_0000, 4'd1, '0, '0));
		send_item(make_item(OP_GET, '1, 4'd8, '0, '0));
		send_item(make_item(OP_CLEAR, rand_word(), 4'd2, rand_word(), 4'd2));
		send_item(make_item(OP_GETSIZE, rand_word(), 4'd5, rand_word(), 4'd5));
	endtask

	// fill to capacity, refuse at full, then deep deletes and refills
	task automatic run_fill_phase();
		logic [WORD_W-1:0] fill_key[$];
		logic [LEN_W-1:0]  fill_len[$];
		logic [WORD_W-1:0] k;
		logic [LEN_W-1:0]  kl;
		int serial;
		int pick;
		serial = 0;
		send_item(make_item(OP_CLEAR, '0, '0, '0, '0));
		while (fill_key.size() < ENTRIES_DEF) begin
			// gap-free stretch over part of the fill
			steady = (fill_key.size() >= 96 && fill_key.size() < 160);
			if (fill_key.size() > 0 && $urandom_range(0, 9) == 0) begin
				pick = $urandom_range(0, fill_key.size() - 1);
				send_item(make_item(OP_GET, fill_key[pick], fill_len[pick], '0, '0));
			end else begin
				// low two bytes carry a serial so every key is new
				kl = 4'($urandom_range(2, KEY_BYTES_DEF));
				k = {48'(rand_word()), 16'(serial)};
				serial++;
				send_item(make_item(OP_SET, k, kl, rand_word(),
					4'($urandom_range(0, VALUE_BYTES_DEF))));
				fill_key = {fill_key, k};
				fill_len = {fill_len, kl};
			end
		end
		steady = 1'b0;
		// full table: new keys refused, replace still works
		repeat (30) begin
			pick = $urandom_range(0, fill_key.size() - 1);
			case ($urandom_range(0, 3))
				0: begin
					send_item(make_item(OP_SET, {48'(rand_word()), 16'(serial)},
						4'($urandom_range(2, KEY_BYTES_DEF)), rand_word(), 4'd8));
					serial++;
				end
				1: send_item(make_item(OP_SET, fill_key[pick], fill_len[pick], rand_word(),
					4'($urandom_range(0, VALUE_BYTES_DEF))));
				2: send_item(make_item(OP_GET, fill_key[pick], fill_len[pick], '0, '0));
				default: send_item(make_item(OP_GETSIZE, '0, '0, '0, '0));
			endcase
		end
		// deletes from the front, the back and between, some followed by appends
		repeat (40) begin
			case ($urandom_range(0, 2))
				0: pick = 0;
				1: pick = fill_key.size() - 1;
				default: pick = $urandom_range(0, fill_key.size() - 1);
			endcase
			send_item(make_item(OP_DELETE, fill_key[pick], fill_len[pick], rand_word(), '0));
			fill_key.delete(pick);
			fill_len.delete(pick);
			if ($urandom_range(0, 2) == 0) begin
				kl = 4'($urandom_range(2, KEY_BYTES_DEF));
				k = {48'(rand_word()), 16'(serial)};
				serial++;
				send_item(make_item(OP_SET, k, kl, rand_word(),
					4'($urandom_range(0, VALUE_BYTES_DEF))));
				fill_key = {fill_key, k};
				fill_len = {fill_len, kl};
			end
			pick = $urandom_range(0, fill_key.size() - 1);
			send_item(make_item(OP_GET, fill_key[pick], fill_len[pick], '0, '0));
		end
		send_item(make_item(OP_GETSIZE, '0, '0, '0, '0));
	endtask

	// random round over a pool of keys; mostly well-formed, some noise
	task automatic run_pool_round(input int count, input int pool_size);
		logic [WORD_W-1:0] pool_key[$];
		logic [LEN_W-1:0]  pool_len[$];
		logic [WORD_W-1:0] k;
		logic [LEN_W-1:0]  kl;
		logic [LEN_W-1:0]  vl;
		logic [OP_W-1:0]   op;
		int idx;
		int roll;
		for (int i = 0; i < pool_size; i++) begin
			pool_len = {pool_len, 4'($urandom_range(1, KEY_BYTES_DEF))};
			pool_key = {pool_key, rand_word()};
		end
		repeat (count) begin
			idx = $urandom_range(0, pool_size - 1);
			kl = pool_len[idx];
			// same key bytes, fresh garbage above the length
			k = keep_bytes(pool_key[idx], kl) | (rand_word() & ~keep_bytes('1, kl));
			vl = 4'($urandom_range(0, VALUE_BYTES_DEF));
			roll = $urandom_range(0, 99);
			if (roll < 36)
				op = OP_SET;
			else if (roll < 64)
				op = OP_GET;
			else if (roll < 79)
				op = OP_DELETE;
			else if (roll < 81)
				op = OP_CLEAR;
			else if (roll < 86)
				op = OP_GETSIZE;
			else begin
				// noise: bad lengths, unknown codes, keys off the pool
				op = 3'($urandom_range(OP_SET, OP_GETSIZE));
				case ($urandom_range(0, 3))
					0: begin
						op = 3'($urandom_range(OP_SET, OP_DELETE));
						kl = $urandom_range(0, 1) ? 4'd0 :
							4'($urandom_range(KEY_BYTES_DEF + 1, LEN_TOP));
					end
					1: begin
						op = OP_SET;
						vl = 4'($urandom_range(VALUE_BYTES_DEF + 1, LEN_TOP));
					end
					2: op = 3'($urandom_range(OP_GETSIZE + 1, OP_TOP));
					default: begin
						k = rand_word();
						kl = 4'($urandom_range(1, KEY_BYTES_DEF));
					end
				endcase
			end
			send_item(make_item(op, k, kl, rand_word(), vl));
		end
	endtask

	// response side: random stall before each item, check on acceptance
	initial begin
		kv_answer_t got;
		int stall;
		response_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (stall > 0) begin
				response_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			response_ch.ready <= 1'b1;
			@(posedge clk);
			while (response_ch.valid !== 1'b1) @(posedge clk);
			got.status = response_ch.status;
			got.found_value = response_ch.found_value;
			got.found_length = response_ch.found_length;
			got.size_now = response_ch.size_now;
			tracker.check_response(got);
		end
	end

	// stimulus and verdict
	initial begin
		int round;
		int pool_sizes[5];
		pool_sizes = '{3, 10, 32, 80, 6};
		round = 0;
		arst_n <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.operation <= OP_GETSIZE;
		request_ch.key_word <= '0;
		request_ch.key_length <= '0;
		request_ch.value_word <= '0;
		request_ch.value_length <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		// hold off until the table has answered everything
		settle_table();
		run_fill_phase();
		settle_table();
		while (items_sent < 1150) begin
			steady = (round % 3 == 1);
			run_pool_round(150, pool_sizes[round % 5]);
			settle_table();
			round++;
		end
		steady = 1'b0;

		// nothing more expected; give a stray response time to show up
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.awaited() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule
